FILE: design/tdf_pkg.sv
// Shared constants, types and saturating Q16.16 helpers for the tracking differentiator.
package tdf_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int NUM_W = DATA_W + FRAC_W;
    localparam int REM_W = DATA_W + 2;
    localparam int ROOT_W = NUM_W / 2;
    localparam int CNT_W = 6;
    localparam int DIV_STEPS = NUM_W;
    localparam int SQRT_STEPS = NUM_W / 2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W = 31;
    localparam int STEP_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] SPEED_RESET = 31'd6553600;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd328;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 31'd0;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_EIGHT = 32'sh0008_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef struct packed {
        logic start;
        logic sqrt;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // signed value from sign and magnitude, saturated
    function automatic q_t sat_mag(input logic neg, input logic [NUM_W-1:0] m);
        logic [NUM_W-1:0] lim;
        logic [NUM_W-1:0] v;
        logic [DATA_W-1:0] lo;
        lim = neg ? NUM_W'(48'h0000_8000_0000) : NUM_W'(48'h0000_7FFF_FFFF);
        v = (m > lim) ? lim : m;
        lo = v[DATA_W-1:0];
        sat_mag = neg ? q_t'(~lo + 32'd1) : q_t'(lo);
    endfunction

    function automatic logic [DATA_W-1:0] mag(input q_t a);
        logic [DATA_W-1:0] ua;
        ua = a;
        mag = a[DATA_W-1] ? (~ua + 32'd1) : ua;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            qadd = s[DATA_W] ? Q_MIN : Q_MAX;
        else
            qadd = s[DATA_W-1:0];
    endfunction

    function automatic q_t qneg(input q_t a);
        qneg = (a == Q_MIN) ? Q_MAX : -a;
    endfunction

    function automatic q_t qabs(input q_t a);
        qabs = a[DATA_W-1] ? qneg(a) : a;
    endfunction

endpackage

FILE: design/tracking_differentiator_fhan.sv
// Top level: Han tracking differentiator with a sequencer over one multiplier and a div/sqrt unit.
//
// Input channel: in_valid / in_stall with target (signed Q16.16). Output channel:
// out_valid / out_stall with tracked_value and tracked_rate (signed Q16.16), one result
// per item. An item is taken when valid is high and stall is low.
// The block works on one item at a time; in_stall is high from acceptance until
// the result has been moved into the output register.
// The square-root path runs when |y| > d0 and the y/h division path otherwise; when
// |a| <= d a further division forms u. Roots and quotients come from the shared
// shift/subtract unit (24 root steps or 48 quotient steps), every product from the single
// 32x32 multiplier. The input reopens in the same cycle that the result is registered.
// A finished result waits in the output register while out_stall is high; the next
// item may already be accepted and computed meanwhile, and it waits in its last step
// until the output register is free.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 speed r, 1 step h,
// 2 output limit); other indexes are ignored. The user must write only while the block
// is idle; the block itself does not enforce this. Reset clears position and velocity
// to zero and loads r = 100.0, h = 328/65536, limit off.
module tracking_differentiator_fhan
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [tdf_pkg::DATA_W-1:0] target,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [tdf_pkg::DATA_W-1:0] tracked_value,
    output logic signed [tdf_pkg::DATA_W-1:0] tracked_rate,
    input  logic                             cfg_we,
    input  logic [tdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tdf_pkg::CFG_W-1:0]        cfg_data
);
    import tdf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_MRH, S_CD, S_CT, S_CD0, S_CMP,
        S_RAD1, S_RAD2, S_RAD3, S_RAD4, S_SQ, S_SQW, S_HALF, S_A1,
        S_DIV1, S_DIVW,
        S_U, S_UP, S_UDIV, S_UDW,
        S_UPD, S_CAP, S_FIN
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    speed_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CFG_W-1:0]    limit_reg;
    q_t x1_reg, x2_reg;
    q_t e_reg, t_reg, d_reg, d0_reg, y_reg, ay_reg, a_reg, u_reg, tmp_reg, tmp2_reg;
    logic [2*DATA_W-1:0] prod_reg;
    logic                prod_neg_reg;
    logic                out_valid_reg;
    q_t value_reg, rate_reg;

    q_t                  r_q, h_q, lim_q;
    q_t                  mul_a, mul_b, mres;
    q_t                  ay_new, x1_new, div_q;
    logic                out_free;
    div_cmd_t            dcmd;
    div_stat_t           dstat;
    logic [NUM_W-1:0]    dnum;
    logic [DATA_W-1:0]   dden;
    logic [NUM_W-1:0]    dres;

    assign r_q = q_t'({1'b0, speed_reg});
    assign h_q = q_t'({{(DATA_W-STEP_W){1'b0}}, step_reg});
    assign lim_q = q_t'({1'b0, limit_reg});
    assign mres = sat_mag(prod_neg_reg, prod_reg[2*DATA_W-1:FRAC_W]);
    assign ay_new = qabs(y_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MRH:
            begin
                mul_a = r_q;
                mul_b = h_q;
            end
            S_CD:
            begin
                mul_a = h_q;
                mul_b = x2_reg;
            end
            S_CT:
            begin
                mul_a = h_q;
                mul_b = d_reg;
            end
            S_CMP:
            begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            S_RAD1:
            begin
                mul_a = Q_EIGHT;
                mul_b = r_q;
            end
            S_RAD3:
            begin
                mul_a = tmp2_reg;
                mul_b = ay_reg;
            end
            S_HALF:
            begin
                mul_a = tmp_reg;
                mul_b = Q_HALF;
            end
            S_U:
            begin
                mul_a = qneg(r_q);
                mul_b = a_reg;
            end
            S_UPD:
            begin
                mul_a = h_q;
                mul_b = u_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // div/sqrt unit command
    always_comb
    begin
        dcmd.start = (state_reg == S_DIV1) || (state_reg == S_SQ) || (state_reg == S_UDIV);
        dcmd.sqrt = (state_reg == S_SQ);
        dnum = '0;
        dden = '0;
        unique case (state_reg)
            S_DIV1:
            begin
                dnum = {mag(y_reg), {FRAC_W{1'b0}}};
                dden = mag(h_q);
            end
            S_SQ:
            begin
                dnum = {mag(tmp_reg), {FRAC_W{1'b0}}};
            end
            S_UDIV:
            begin
                dnum = {mag(tmp_reg), {FRAC_W{1'b0}}};
                dden = mag(d_reg);
            end
            default:
            begin
                dnum = '0;
                dden = '0;
            end
        endcase
    end

    // signed quotient of the running division; zero dividend gives zero
    always_comb
    begin
        if (state_reg == S_DIVW)
            div_q = (y_reg == '0) ? '0 : sat_mag(y_reg[DATA_W-1], dres);
        else
            div_q = (tmp_reg == '0) ? '0 : sat_mag(tmp_reg[DATA_W-1] ^ d_reg[DATA_W-1], dres);
    end

    always_comb
    begin
        x1_new = qadd(x1_reg, t_reg);
        if (limit_reg != '0)
        begin
            if (x1_new > lim_q)
                x1_new = lim_q;
            if (x1_new < -lim_q)
                x1_new = -lim_q;
        end
    end

    tdf_divsqrt u_divsqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dcmd),
        .num   (dnum),
        .den   (dden),
        .stat  (dstat),
        .res   (dres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            speed_reg <= SPEED_RESET;
            step_reg <= STEP_RESET;
            limit_reg <= LIMIT_RESET;
            x1_reg <= '0;
            x2_reg <= '0;
            e_reg <= '0;
            t_reg <= '0;
            d_reg <= '0;
            d0_reg <= '0;
            y_reg <= '0;
            ay_reg <= '0;
            a_reg <= '0;
            u_reg <= '0;
            tmp_reg <= '0;
            tmp2_reg <= '0;
            prod_reg <= '0;
            prod_neg_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            value_reg <= '0;
            rate_reg <= '0;
        end
        else
        begin
            prod_reg <= mag(mul_a) * mag(mul_b);
            prod_neg_reg <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];

            // a commit in S_FIN sets the flag instead
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SPEED: speed_reg <= cfg_data;
                    REG_STEP:  step_reg <= cfg_data[STEP_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_data;
                    default:   ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        e_reg <= qadd(x1_reg, qneg(target));
                        state_reg <= S_MRH;
                    end
                end
                S_MRH: state_reg <= S_CD;
                S_CD:
                begin
                    d_reg <= mres;
                    state_reg <= S_CT;
                end
                S_CT:
                begin
                    t_reg <= mres;
                    state_reg <= S_CD0;
                end
                S_CD0:
                begin
                    d0_reg <= mres;
                    y_reg <= qadd(e_reg, t_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    ay_reg <= ay_new;
                    state_reg <= (ay_new > d0_reg) ? S_RAD1 : S_DIV1;
                end
                S_RAD1:
                begin
                    tmp_reg <= mres;
                    state_reg <= S_RAD2;
                end
                S_RAD2:
                begin
                    tmp2_reg <= mres;
                    state_reg <= S_RAD3;
                end
                S_RAD3: state_reg <= S_RAD4;
                S_RAD4:
                begin
                    tmp_reg <= qadd(tmp_reg, mres);
                    state_reg <= S_SQ;
                end
                S_SQ: state_reg <= S_SQW;
                S_SQW:
                begin
                    if (dstat.done)
                    begin
                        tmp_reg <= qadd(sat_mag(1'b0, dres), qneg(d_reg));
                        state_reg <= S_HALF;
                    end
                end
                S_HALF: state_reg <= S_A1;
                S_A1:
                begin
                    a_reg <= (y_reg > 0) ? qadd(x2_reg, mres) : qadd(x2_reg, qneg(mres));
                    state_reg <= S_U;
                end
                S_DIV1: state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (dstat.done)
                    begin
                        a_reg <= qadd(x2_reg, div_q);
                        state_reg <= S_U;
                    end
                end
                S_U:
                begin
                    if (qabs(a_reg) > d_reg)
                    begin
                        u_reg <= (a_reg > 0) ? qneg(r_q) : r_q;
                        state_reg <= S_UPD;
                    end
                    else
                        state_reg <= S_UP;
                end
                S_UP:
                begin
                    tmp_reg <= mres;
                    state_reg <= S_UDIV;
                end
                S_UDIV: state_reg <= S_UDW;
                S_UDW:
                begin
                    if (dstat.done)
                    begin
                        u_reg <= div_q;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: state_reg <= S_CAP;
                S_CAP:
                begin
                    tmp_reg <= mres;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        x1_reg <= x1_new;
                        x2_reg <= qadd(x2_reg, tmp_reg);
                        value_reg <= x1_new;
                        rate_reg <= qadd(x2_reg, tmp_reg);
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign tracked_value = value_reg;
    assign tracked_rate = rate_reg;

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.start |-> !dstat.busy)
        else $error("div/sqrt started while busy");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.done |-> (state_reg == S_SQW || state_reg == S_DIVW || state_reg == S_UDW))
        else $error("div/sqrt result not awaited");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && limit_reg != '0) |-> (value_reg <= lim_q && value_reg >= -lim_q))
        else $error("tracked value outside limit");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && out_stall) |=> state_reg == S_FIN)
        else $error("result committed over a pending result");

endmodule

FILE: design/tdf_divsqrt.sv
// Radix-2 divider and digit-by-digit square root sharing one subtractor.
module tdf_divsqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tdf_pkg::div_cmd_t            cmd,
    input  logic [tdf_pkg::NUM_W-1:0]    num,
    input  logic [tdf_pkg::DATA_W-1:0]   den,
    output tdf_pkg::div_stat_t           stat,
    output logic [tdf_pkg::NUM_W-1:0]    res
);
    import tdf_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic                sqrt_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DATA_W-1:0]   den_reg;

    logic [REM_W-1:0]    shifted;
    logic [REM_W-1:0]    operand;
    logic [REM_W-1:0]    trial;
    logic                take;

    always_comb
    begin
        if (sqrt_reg)
        begin
            shifted = {rem_reg[REM_W-3:0], num_reg[NUM_W-1 -: 2]};
            operand = {{(REM_W-ROOT_W-2){1'b0}}, quo_reg[ROOT_W-1:0], 2'b01};
        end
        else
        begin
            shifted = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
            operand = {2'b00, den_reg};
        end
        trial = shifted - operand;
        take = !trial[REM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg <= '0;
            num_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= cmd.sqrt;
                cnt_reg <= cmd.sqrt ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= take ? trial : shifted;
                quo_reg <= {quo_reg[NUM_W-2:0], take};
                num_reg <= sqrt_reg ? {num_reg[NUM_W-3:0], 2'b00} : {num_reg[NUM_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res = quo_reg;

endmodule

FILE: sim/tb_tracking_differentiator_fhan.sv
// Self-checking testbench for the fhan tracking differentiator with a bit-exact predictor.
`timescale 1ns / 1ps

module tb_tracking_differentiator_fhan;
    import tdf_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 150;

    typedef logic [63:0] u64;

    typedef struct {
        q_t value;
        q_t rate;
    } track_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    q_t                   target;
    logic                 out_valid;
    logic                 out_stall;
    q_t                   tracked_value;
    q_t                   tracked_rate;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    track_t expected_tracks[$];
    longint pos_m, vel_m, speed_m, step_m, limit_m;
    int     errors = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    bit     no_gaps = 0;
    int     stall_mode = 0;
    int     stall_left = 0;

    tracking_differentiator_fhan uut (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic u64 mag64(longint v);
        return v < 0 ? u64'(-v) : u64'(v);
    endfunction

    function automatic longint from_mag(bit neg, u64 m);
        u64 lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (m > lim)
            m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat32(longint v);
        return from_mag(v < 0, mag64(v));
    endfunction

    function automatic longint f_add(longint a, longint b);
        return sat32(a + b);
    endfunction

    function automatic longint f_neg(longint a);
        return sat32(-a);
    endfunction

    function automatic longint f_sub(longint a, longint b);
        return f_add(a, f_neg(b));
    endfunction

    function automatic longint f_abs(longint a);
        return a < 0 ? f_neg(a) : a;
    endfunction

    function automatic longint f_mul(longint a, longint b);
        u64 p;
        p = (mag64(a) * mag64(b)) >> FRAC_W;
        return from_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint f_div(longint a, longint b);
        u64 q;
        if (b == 0)
            return a == 0 ? 0 : from_mag(a < 0, 64'h1_0000_0000);
        q = (mag64(a) << FRAC_W) / mag64(b);
        return from_mag((a < 0) != (b < 0), q);
    endfunction

    function automatic longint f_sqrt(longint v);
        u64 n;
        u64 root;
        u64 c;
        n = mag64(v) << FRAC_W;
        root = 0;
        for (int b = 24; b >= 0; b--)
        begin
            c = root | (u64'(1) << b);
            if (c * c <= n)
                root = c;
        end
        return from_mag(1'b0, root);
    endfunction

    // time-optimal synthesis function, returns acceleration u
    function automatic longint fhan_accel(longint e, longint x2, longint r, longint h);
        longint d, d0, y, ay, rad, half_step, a;
        d = f_mul(r, h);
        d0 = f_mul(h, d);
        y = f_add(e, f_mul(h, x2));
        ay = f_abs(y);
        if (ay > d0)
        begin
            rad = f_add(f_mul(d, d), f_mul(f_mul(longint'(Q_EIGHT), r), ay));
            half_step = f_mul(f_sub(f_sqrt(rad), d), longint'(Q_HALF));
            a = (y > 0) ? f_add(x2, half_step) : f_sub(x2, half_step);
        end
        else
            a = f_add(x2, f_div(y, h));
        if (f_abs(a) > d)
            return a > 0 ? f_neg(r) : r;
        return f_div(f_mul(f_neg(r), a), d);
    endfunction

    function automatic track_t track_step(q_t tgt);
        longint u;
        track_t t;
        u = fhan_accel(f_sub(pos_m, longint'(tgt)), vel_m, speed_m, step_m);
        pos_m = f_add(pos_m, f_mul(step_m, vel_m));
        vel_m = f_add(vel_m, f_mul(step_m, u));
        if (limit_m != 0)
        begin
            if (pos_m > limit_m)
                pos_m = limit_m;
            if (pos_m < -limit_m)
                pos_m = -limit_m;
        end
        t.value = q_t'(pos_m);
        t.rate = q_t'(vel_m);
        return t;
    endfunction

    // ---------------- monitors ----------------
    always @(posedge clk)
    begin
        track_t exp_t;
        if (rst_n && in_valid && !in_stall)
            expected_tracks.push_back(track_step(target));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tracks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%0d rate=%0d",
                         $time, tracked_value, tracked_rate);
            end
            else
            begin
                exp_t = expected_tracks.pop_front();
                if (tracked_value !== exp_t.value)
                begin
                    errors++;
                    $display("%0t: tracked_value expected %0d actual %0d",
                             $time, exp_t.value, tracked_value);
                end
                if (tracked_rate !== exp_t.rate)
                begin
                    errors++;
                    $display("%0t: tracked_rate expected %0d actual %0d",
                             $time, exp_t.rate, tracked_rate);
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern: modes change every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(40, 300);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 37) < 15;
        endcase
    end

    // ---------------- drivers ----------------
    task automatic send_target(q_t v);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        target <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else if (!no_gaps)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 12);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tracks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_SPEED: speed_m = longint'(val);
            REG_STEP:  step_m = longint'(val[STEP_W-1:0]);
            REG_LIMIT: limit_m = longint'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [CFG_W-1:0] r, logic [CFG_W-1:0] h, logic [CFG_W-1:0] lim);
        wait_drained();
        write_reg(REG_SPEED, r);
        write_reg(REG_STEP, h);
        write_reg(REG_LIMIT, lim);
    endtask

    function automatic q_t random_target(q_t held);
        case ($urandom_range(0, 7))
            0: return q_t'($urandom);
            1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            2: return q_t'($signed($urandom_range(0, 2097152)) - 1048576);
            3: return q_t'($signed($urandom_range(0, 65536)) - 32768);
            default: return held;
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        no_gaps = 1;
        send_target(32'sh0001_0000);
        send_target(32'sh0001_0000);
        send_target(0);
        send_target(Q_MAX);
        send_target(Q_MAX);
        send_target(Q_MIN);
        send_target(Q_MIN);
        send_target(-1);
        send_target(1);
        no_gaps = 0;
    endtask

    task automatic test_register_extremes();
        // unknown register index must be ignored
        wait_drained();
        write_reg(2'd3, 31'h7FFF_FFFF);
        send_target(32'sh0010_0000);
        // zero step: divisions by zero
        configure(31'd6553600, 31'd0, 31'd0);
        send_target(32'sh0005_0000);
        send_target(-32'sh0005_0000);
        // tiny r*h truncates to zero
        configure(31'd1, 31'd1, 31'd0);
        send_target(Q_MAX);
        send_target(0);
        // largest r, h = 1.0, clamp active
        configure(31'h7FFF_FFFF, 31'd65536, 31'h0003_0000);
        send_target(Q_MAX);
        send_target(Q_MIN);
        send_target(0);
        // oversized step masked to 17 bits, widest limit
        configure(31'h0001_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_target(Q_MIN);
        send_target(Q_MAX);
        configure(31'h7FFF_FFFF, 31'd1, 31'd1);
        send_target(Q_MAX);
        send_target(Q_MIN);
    endtask

    task automatic random_phase(int count);
        q_t held;
        held = q_t'($urandom);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                held = q_t'($signed($urandom_range(0, 8388608)) - 4194304);
            if ($urandom_range(0, 99) == 0)
                no_gaps = !no_gaps;
            send_target(random_target(held));
        end
        no_gaps = 0;
    endtask

    task automatic test_random_settings();
        configure(SPEED_RESET, 31'(STEP_RESET), LIMIT_RESET);
        random_phase(250);
        configure(31'h0064_0000, 31'h0000_0CCD, 31'h0020_0000);
        random_phase(200);
        configure(31'($urandom), 31'($urandom), 31'($urandom));
        random_phase(150);
        configure(31'h7FFF_FFFF, 31'd65536, 31'd0);
        random_phase(150);
        configure(31'($urandom_range(1, 65536)), 31'($urandom_range(1, 2000)),
                  31'($urandom_range(0, 1) ? $urandom : 0));
        random_phase(150);
        configure(31'd1, 31'd0, 31'h7FFF_FFFF);
        random_phase(100);
        configure(31'h000A_0000, 31'd65535, 31'h0000_8000);
        random_phase(100);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        target = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pos_m = 0;
        vel_m = 0;
        speed_m = longint'(SPEED_RESET);
        step_m = longint'(STEP_RESET);
        limit_m = longint'(LIMIT_RESET);
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        wait_drained();

        if (errors == 0 && expected_tracks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
